/* rtl/core/tepq_pkg.sv */
package tepq_pkg;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;
	localparam logic [1:0] ACT_CANCEL = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	typedef struct packed {
		logic [31:0] etime;
		logic [7:0]  etype;
		logic [15:0] eid;
	} entry_t;

	typedef struct packed {
		logic [1:0] op;
		logic       commit;
		entry_t     ent;
	} cell_cmd_t;

endpackage

/* rtl/core/tepq_cell.sv */
module tepq_cell (
	input  logic                 clk,
	input  tepq_pkg::cell_cmd_t  cmd,
	input  logic                 live,
	input  logic                 flag_in,
	input  tepq_pkg::entry_t     left_entry,
	input  tepq_pkg::entry_t     right_entry,
	output logic                 flag_out,
	output logic                 hit,
	output tepq_pkg::entry_t     entry
);

	tepq_pkg::entry_t entry_q;
	logic le;
	logic match;

	assign le    = live && (entry_q.etime <= cmd.ent.etime);
	assign match = live && (entry_q.etype == cmd.ent.etype);
	assign hit   = match && !flag_in;
	assign entry = entry_q;

	// insert: flag is "this slot stays"; cancel: first match at or before here; pop: all shift
	always_comb begin
		case (cmd.op)
			tepq_pkg::ACT_INSERT: flag_out = le;
			tepq_pkg::ACT_POP:    flag_out = 1'b1;
			tepq_pkg::ACT_CANCEL: flag_out = flag_in || match;
			default:              flag_out = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (cmd.op)
				tepq_pkg::ACT_INSERT: begin
					if (!le) begin
						entry_q <= flag_in ? cmd.ent : left_entry;
					end
				end
				tepq_pkg::ACT_POP: begin
					entry_q <= right_entry;
				end
				tepq_pkg::ACT_CANCEL: begin
					if (flag_in || match) begin
						entry_q <= right_entry;
					end
				end
				default: begin
					entry_q <= entry_q;
				end
			endcase
		end
	end

endmodule

/* rtl/core/timed_event_priority_queue.sv */
// Sorted event queue of QUEUE_DEPTH entries held in a row of cells, index 0 earliest.
// Command channel: start with action, event_time, event_type, event_id; a beat is
// taken at a rising edge with start high and busy low.
// Actions: insert (placed after all entries of earlier or equal time), pop
// (earliest entry out, sim_time set to its time), cancel (first entry of
// event_type out).
// Result channel: done is high for exactly one cycle with status, out_time,
// out_type, out_id, occupancy and sim_time; the receiver cannot hold it off.
// The accepting edge enters EXEC; the result is registered as EXEC ends.
// A command is taken only in IDLE; busy is high for the one cycle in which
// every cell compares against the command and loads from a neighbor in parallel.
// Full, empty and no-match cases leave the queue unchanged and are flagged in status.
// occupancy reports the entry count in 5 bits.
// Reset (arst_n low) empties the queue and clears sim_time; no clearing pass.
module timed_event_priority_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] event_time,
	input  logic [7:0]  event_type,
	input  logic [15:0] event_id,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] out_time,
	output logic [7:0]  out_type,
	output logic [15:0] out_id,
	output logic [4:0]  occupancy,
	output logic [31:0] sim_time
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

	typedef enum logic {IDLE, EXEC} state_t;

	state_t              state_q;
	logic [1:0]          op_q;
	tepq_pkg::entry_t    ent_q;
	logic [CW-1:0]       count_q;
	logic [31:0]         clock_q;
	logic                done_q;
	logic [1:0]          status_q;
	tepq_pkg::entry_t    out_q;

	tepq_pkg::cell_cmd_t cmd;
	tepq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0]   flag;
	logic [QUEUE_DEPTH-1:0] hit;
	tepq_pkg::entry_t    hit_entry;
	logic [1:0]          st;
	logic                exec;

	assign exec = (state_q == EXEC);

	always_comb begin
		st = tepq_pkg::ST_OK;
		case (op_q)
			tepq_pkg::ACT_INSERT: begin
				if (count_q == FULL_COUNT) st = tepq_pkg::ST_FULL;
			end
			tepq_pkg::ACT_POP: begin
				if (count_q == '0) st = tepq_pkg::ST_EMPTY;
			end
			tepq_pkg::ACT_CANCEL: begin
				if (count_q == '0) st = tepq_pkg::ST_EMPTY;
				else if (!flag[QUEUE_DEPTH]) st = tepq_pkg::ST_NOMATCH;
			end
			default: st = tepq_pkg::ST_OK;
		endcase
	end

	assign cmd.op     = op_q;
	assign cmd.ent    = ent_q;
	assign cmd.commit = exec && (st == tepq_pkg::ST_OK);
	assign flag[0]    = (op_q != tepq_pkg::ACT_CANCEL);

	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			tepq_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.live       (CW'(g) < count_q),
				.flag_in    (flag[g]),
				.left_entry (cell_entry[(g == 0) ? 0 : g - 1]),
				.right_entry(cell_entry[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
				.flag_out   (flag[g + 1]),
				.hit        (hit[g]),
				.entry      (cell_entry[g])
			);
		end
	endgenerate

	always_comb begin
		hit_entry = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (hit[i]) hit_entry = hit_entry | cell_entry[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			count_q  <= '0;
			clock_q  <= '0;
			done_q   <= 1'b0;
			status_q <= tepq_pkg::ST_OK;
			out_q    <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					state_q  <= IDLE;
					done_q   <= 1'b1;
					status_q <= st;
					if (st == tepq_pkg::ST_OK) begin
						case (op_q)
							tepq_pkg::ACT_INSERT: begin
								count_q <= count_q + 1'b1;
								out_q   <= '0;
							end
							tepq_pkg::ACT_POP: begin
								count_q <= count_q - 1'b1;
								clock_q <= cell_entry[0].etime;
								out_q   <= cell_entry[0];
							end
							tepq_pkg::ACT_CANCEL: begin
								count_q <= count_q - 1'b1;
								out_q   <= hit_entry;
							end
							default: begin
								out_q <= '0;
							end
						endcase
					end else begin
						out_q <= '0;
					end
				end
				default: begin
					state_q <= IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !exec) begin
			op_q        <= action;
			ent_q.etime <= event_time;
			ent_q.etype <= event_type;
			ent_q.eid   <= event_id;
		end
	end

	assign busy      = exec;
	assign done      = done_q;
	assign status    = status_q;
	assign out_time  = out_q.etime;
	assign out_type  = out_q.etype;
	assign out_id    = out_q.eid;
	assign occupancy = 5'(count_q);
	assign sim_time  = clock_q;

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a preceding execute cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above queue depth");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat not executed");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == tepq_pkg::ST_EMPTY |-> count_q == '0)
		else $error("empty status with entries held");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == tepq_pkg::ST_FULL |-> count_q == FULL_COUNT)
		else $error("full status with free slots");

endmodule

/* tb/sv/tb_timed_event_priority_queue.sv */
`timescale 1ns / 100ps

module tb_timed_event_priority_queue;

	localparam int          QDEPTH      = 16;
	localparam logic [1:0]  ACT_NOP     = 2'd3;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          RAND_CMDS   = 1500;

	typedef struct {
		logic [1:0]  act;
		logic [31:0] etime;
		logic [7:0]  etype;
		logic [15:0] eid;
		int          gap;
	} cmd_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] out_time;
		logic [7:0]  out_type;
		logic [15:0] out_id;
		logic [4:0]  occupancy;
		logic [31:0] sim_time;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [31:0] event_time;
	logic [7:0]  event_type;
	logic [15:0] event_id;
	logic        done;
	logic [1:0]  status;
	logic [31:0] out_time;
	logic [7:0]  out_type;
	logic [15:0] out_id;
	logic [4:0]  occupancy;
	logic [31:0] sim_time;

	cmd_t   cmd_backlog[$];
	reply_t awaited_replies[$];
	int     cmd_total;
	int     accepted_cnt;
	int     mismatches;
	int     idle_pct;
	int     cycle_cnt;
	logic   beat_taken;

	// shadow of the queue contents
	tepq_pkg::entry_t shadow_slot[QDEPTH];
	int               shadow_count;
	logic [31:0]      shadow_now;

	// driver state
	cmd_t cur_cmd;
	bit   have_cmd;
	int   hold_cnt;

	timed_event_priority_queue #(.QUEUE_DEPTH(QDEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.event_time(event_time),
		.event_type(event_type),
		.event_id(event_id),
		.done(done),
		.status(status),
		.out_time(out_time),
		.out_type(out_type),
		.out_id(out_id),
		.occupancy(occupancy),
		.sim_time(sim_time)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic void shadow_remove(int pos);
		int i;
		for (i = pos; i + 1 < shadow_count; i++)
			shadow_slot[i] = shadow_slot[i + 1];
		shadow_count--;
	endfunction

	function automatic reply_t shadow_apply(cmd_t c);
		reply_t r;
		int     pos;
		int     i;
		bit     hit;
		r = '{tepq_pkg::ST_OK, 32'd0, 8'd0, 16'd0, 5'd0, 32'd0};
		case (c.act)
			tepq_pkg::ACT_INSERT: begin
				if (shadow_count >= QDEPTH) begin
					r.status = tepq_pkg::ST_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_slot[pos].etime <= c.etime)
						pos++;
					for (i = shadow_count; i > pos; i--)
						shadow_slot[i] = shadow_slot[i - 1];
					shadow_slot[pos].etime = c.etime;
					shadow_slot[pos].etype = c.etype;
					shadow_slot[pos].eid   = c.eid;
					shadow_count++;
				end
			end
			tepq_pkg::ACT_POP: begin
				if (shadow_count == 0) begin
					r.status = tepq_pkg::ST_EMPTY;
				end else begin
					r.out_time = shadow_slot[0].etime;
					r.out_type = shadow_slot[0].etype;
					r.out_id   = shadow_slot[0].eid;
					shadow_remove(0);
					shadow_now = r.out_time;
				end
			end
			tepq_pkg::ACT_CANCEL: begin
				if (shadow_count == 0) begin
					r.status = tepq_pkg::ST_EMPTY;
				end else begin
					hit = 1'b0;
					for (i = 0; i < shadow_count && !hit; i++) begin
						if (shadow_slot[i].etype == c.etype) begin
							hit = 1'b1;
							pos = i;
						end
					end
					if (hit) begin
						r.out_time = shadow_slot[pos].etime;
						r.out_type = shadow_slot[pos].etype;
						r.out_id   = shadow_slot[pos].eid;
						shadow_remove(pos);
					end else begin
						r.status = tepq_pkg::ST_NOMATCH;
					end
				end
			end
			default: ;
		endcase
		r.occupancy = shadow_count[4:0];
		r.sim_time  = shadow_now;
		return r;
	endfunction

	function automatic void add_cmd(logic [1:0] act, logic [31:0] t, logic [7:0] ty,
			logic [15:0] id);
		cmd_t c;
		c.act   = act;
		c.etime = t;
		c.etype = ty;
		c.eid   = id;
		c.gap   = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
		cmd_backlog.push_back(c);
		cmd_total++;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// driver: one beat held until taken, optional idle burst before each
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || beat_taken) begin
			if (!have_cmd && cmd_backlog.size() != 0) begin
				cur_cmd  = cmd_backlog.pop_front();
				have_cmd = 1'b1;
				hold_cnt = cur_cmd.gap;
			end
			if (have_cmd && hold_cnt == 0) begin
				start      <= 1'b1;
				action     <= cur_cmd.act;
				event_time <= cur_cmd.etime;
				event_type <= cur_cmd.etype;
				event_id   <= cur_cmd.eid;
				have_cmd   = 1'b0;
			end else begin
				start <= 1'b0;
				if (hold_cnt != 0)
					hold_cnt--;
			end
		end
	end

	// monitor: predict on accepted beats, check on done
	always @(posedge clk) begin
		if (!arst_n) begin
			beat_taken <= 1'b0;
		end else begin
			reply_t got;
			reply_t want;
			beat_taken <= start && !busy;
			if (done) begin
				got = '{status, out_time, out_type, out_id, occupancy, sim_time};
				if (awaited_replies.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected result, expected none, actual status %0d",
						$time, status);
				end else begin
					want = awaited_replies.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("out_time", want.out_time, got.out_time);
					check_field("out_type", 32'(want.out_type), 32'(got.out_type));
					check_field("out_id", 32'(want.out_id), 32'(got.out_id));
					check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
					check_field("sim_time", want.sim_time, got.sim_time);
				end
			end
			if (start && !busy) begin
				cmd_t c;
				c.act   = action;
				c.etime = event_time;
				c.etype = event_type;
				c.eid   = event_id;
				c.gap   = 0;
				awaited_replies.push_back(shadow_apply(c));
				accepted_cnt++;
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[timed_event_priority_queue] ERROR");
		$finish;
	end

	initial begin
		int n;
		int ins_pct;
		int r;
		logic [1:0]  a;
		logic [31:0] t;
		logic [7:0]  ty;

		start        = 1'b0;
		action       = ACT_NOP;
		event_time   = '0;
		event_type   = '0;
		event_id     = '0;
		have_cmd     = 1'b0;
		hold_cnt     = 0;
		cmd_total    = 0;
		accepted_cnt = 0;
		mismatches   = 0;
		shadow_count = 0;
		shadow_now   = '0;
		idle_pct     = 25;
		ins_pct      = 50;

		add_cmd(tepq_pkg::ACT_POP, 32'd0, 8'd0, 16'd0);
		add_cmd(tepq_pkg::ACT_CANCEL, 32'd0, 8'hFF, 16'd0);
		add_cmd(tepq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
		add_cmd(tepq_pkg::ACT_INSERT, 32'h0000_0000, 8'h00, 16'h0000);
		add_cmd(tepq_pkg::ACT_INSERT, 32'h0001_0000, 8'h05, 16'h0001);
		add_cmd(tepq_pkg::ACT_INSERT, 32'h0001_0000, 8'h05, 16'h0002);
		add_cmd(tepq_pkg::ACT_CANCEL, 32'd0, 8'h07, 16'd0);
		add_cmd(tepq_pkg::ACT_CANCEL, 32'd0, 8'h05, 16'd0);
		add_cmd(tepq_pkg::ACT_POP, 32'd0, 8'd0, 16'd0);
		add_cmd(tepq_pkg::ACT_POP, 32'd0, 8'd0, 16'd0);
		// earlier than the clock: pop moves it backwards
		add_cmd(tepq_pkg::ACT_INSERT, 32'h0000_8000, 8'h01, 16'h1234);
		add_cmd(tepq_pkg::ACT_POP, 32'd0, 8'd0, 16'd0);
		add_cmd(ACT_NOP, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
		for (n = 0; n < QDEPTH - 1; n++)
			add_cmd(tepq_pkg::ACT_INSERT, $urandom_range(0, 32'h00FF_FFFF), 8'h10 + n[7:0],
				16'($urandom));
		add_cmd(tepq_pkg::ACT_INSERT, 32'h0000_0001, 8'h20, 16'hAAAA);
		// type only in the last slot
		add_cmd(tepq_pkg::ACT_CANCEL, 32'd0, 8'hFF, 16'd0);
		add_cmd(tepq_pkg::ACT_CANCEL, 32'd0, 8'h10, 16'd0);

		for (n = 0; n < RAND_CMDS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 3))
					0: ins_pct = 85;
					1: ins_pct = 50;
					2: ins_pct = 20;
					default: ins_pct = 60;
				endcase
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 25;
					default: idle_pct = 50;
				endcase
			end
			if (n >= RAND_CMDS - 150)
				idle_pct = 0;
			r = $urandom_range(0, 99);
			if (r < 3)
				a = ACT_NOP;
			else if ($urandom_range(0, 99) < ins_pct)
				a = tepq_pkg::ACT_INSERT;
			else if ($urandom_range(0, 2) == 0)
				a = tepq_pkg::ACT_CANCEL;
			else
				a = tepq_pkg::ACT_POP;
			case ($urandom_range(0, 3))
				0: t = $urandom;
				1: t = $urandom_range(0, 15);
				2: t = {8'd0, 8'($urandom_range(0, 255)), 16'h0000};
				default: t = $urandom & 32'h000F_FFFF;
			endcase
			ty = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7))
				: 8'($urandom_range(0, 255));
			add_cmd(a, t, ty, 16'($urandom));
		end

		while (accepted_cnt < cmd_total || awaited_replies.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("[timed_event_priority_queue] OK");
		else
			$display("[timed_event_priority_queue] ERROR");
		$finish;
	end

endmodule
